// ----- rtl/core/etud_pkg.sv -----
// Shared types, constants and helpers for the escape-to-UTF-8 decoder.
package etud_pkg;

  localparam int CP_W            = 31;
  localparam int LEN_W           = 3;
  localparam int QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic [CP_W-1:0]  data;
    logic [LEN_W-1:0] len;
    logic             last;
    logic             error;
  } job_t;

  function automatic logic [7:0] lead_byte(input logic [LEN_W-1:0] len);
    logic [7:0] lead;
    case (len)
      LEN_W'(2): lead = 8'hC0;
      LEN_W'(3): lead = 8'hE0;
      LEN_W'(4): lead = 8'hF0;
      LEN_W'(5): lead = 8'hF8;
      LEN_W'(6): lead = 8'hFC;
      default:   lead = 8'h00;
    endcase
    return lead;
  endfunction

endpackage

// ----- rtl/core/etud_front.sv -----
// Front end: accepts items, tracks escape state and issues output jobs.
module etud_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          kind,
  input  logic [7:0]    in_byte,
  input  logic          q_full,
  output logic          push,
  output etud_pkg::job_t push_job
);
  import etud_pkg::*;

  typedef enum logic [1:0] {MODE_PLAIN, MODE_AFTER_BS, MODE_HEX} mode_t;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_LU     = 8'h75;
  localparam logic [7:0] CH_UU     = 8'h55;
  localparam logic [7:0] CODE_ESC  = 8'h1B;

  mode_t       mode, mode_next;
  logic [3:0]  digits, digits_next, digits_dec;
  logic [31:0] acc, acc_next, acc_shift;
  logic        error_seen, error_seen_next;
  logic        take, push_raw;
  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [LEN_W-1:0] cp_len;
  job_t        job;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;
  assign push     = take && push_raw;
  assign push_job = job;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_val = in_byte[3:0];
    end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                 (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
      hex_val = in_byte[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign acc_shift  = {acc[27:0], hex_val};
  assign digits_dec = (digits == 4'd0) ? 4'd0 : digits - 4'd1;

  always_comb begin
    if (acc_shift[30:7] == '0) begin
      cp_len = LEN_W'(1);
    end else if (acc_shift[30:11] == '0) begin
      cp_len = LEN_W'(2);
    end else if (acc_shift[30:16] == '0) begin
      cp_len = LEN_W'(3);
    end else if (acc_shift[30:21] == '0) begin
      cp_len = LEN_W'(4);
    end else if (acc_shift[30:26] == '0) begin
      cp_len = LEN_W'(5);
    end else begin
      cp_len = LEN_W'(6);
    end
  end

  always_comb begin
    mode_next       = mode;
    digits_next     = digits;
    acc_next        = acc;
    error_seen_next = error_seen;
    push_raw        = 1'b0;
    job.data        = '0;
    job.len         = LEN_W'(1);
    job.last        = 1'b0;
    job.error       = 1'b0;
    if (kind) begin
      mode_next       = MODE_PLAIN;
      digits_next     = 4'd0;
      acc_next        = '0;
      error_seen_next = 1'b0;
      if (!error_seen) begin
        push_raw  = 1'b1;
        job.last  = 1'b1;
        job.error = (mode == MODE_AFTER_BS) || (mode == MODE_HEX);
      end
    end else if (!error_seen) begin
      case (mode)
        MODE_AFTER_BS: begin
          mode_next = MODE_PLAIN;
          push_raw  = 1'b1;
          job.data  = {{(CP_W-8){1'b0}}, in_byte};
          case (in_byte)
            CH_A:    job.data[7:0] = 8'h07;
            CH_B:    job.data[7:0] = 8'h08;
            CH_T:    job.data[7:0] = 8'h09;
            CH_N:    job.data[7:0] = 8'h0A;
            CH_V:    job.data[7:0] = 8'h0B;
            CH_F:    job.data[7:0] = 8'h0C;
            CH_R:    job.data[7:0] = 8'h0D;
            CH_E:    job.data[7:0] = CODE_ESC;
            CH_X: begin
              push_raw = 1'b0; mode_next = MODE_HEX; digits_next = 4'd2; acc_next = '0;
            end
            CH_LU: begin
              push_raw = 1'b0; mode_next = MODE_HEX; digits_next = 4'd4; acc_next = '0;
            end
            CH_UU: begin
              push_raw = 1'b0; mode_next = MODE_HEX; digits_next = 4'd8; acc_next = '0;
            end
            default: ;
          endcase
        end
        MODE_HEX: begin
          if (!hex_ok) begin
            mode_next       = MODE_PLAIN;
            digits_next     = 4'd0;
            acc_next        = '0;
            error_seen_next = 1'b1;
            push_raw        = 1'b1;
            job.last        = 1'b1;
            job.error       = 1'b1;
          end else begin
            acc_next    = acc_shift;
            digits_next = digits_dec;
            if (digits_dec == 4'd0) begin
              mode_next = MODE_PLAIN;
              acc_next  = '0;
              push_raw  = 1'b1;
              if (acc_shift[31]) begin
                digits_next     = 4'd0;
                error_seen_next = 1'b1;
                job.last        = 1'b1;
                job.error       = 1'b1;
              end else begin
                job.data = acc_shift[CP_W-1:0];
                job.len  = cp_len;
              end
            end
          end
        end
        default: begin
          mode_next = MODE_PLAIN;
          if (in_byte == CH_BSLASH) begin
            mode_next = MODE_AFTER_BS;
          end else begin
            push_raw = 1'b1;
            job.data = {{(CP_W-8){1'b0}}, in_byte};
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_PLAIN;
      digits     <= 4'd0;
      acc        <= '0;
      error_seen <= 1'b0;
    end else if (take) begin
      mode       <= mode_next;
      digits     <= digits_next;
      acc        <= acc_next;
      error_seen <= error_seen_next;
    end
  end

  a_error_plain: assert property (@(posedge clk) disable iff (rst)
    error_seen |-> (mode == MODE_PLAIN && digits == 4'd0))
    else $error("front: error state left escape open");

endmodule

// ----- rtl/core/etud_queue.sv -----
// Short job queue between the front end and the UTF-8 back end.
module etud_queue #(
  parameter int DEPTH = etud_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  etud_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output etud_pkg::job_t head
);
  import etud_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign q_valid = (count != '0);
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue: push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> q_valid)
    else $error("queue: pop while empty");

endmodule

// ----- rtl/core/etud_back.sv -----
// Back end: expands jobs into UTF-8 bytes behind an output register.
module etud_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  etud_pkg::job_t q_job,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           last,
  output logic           error
);
  import etud_pkg::*;

  logic             active;
  job_t             held;
  logic [LEN_W-1:0] rem;
  job_t             cur;
  logic             cur_valid, fire;
  logic [LEN_W-1:0] idx;
  logic [CP_W-1:0]  shifted;
  logic [7:0]       byte_val;

  assign cur       = active ? held : q_job;
  assign cur_valid = active || q_valid;
  assign idx       = active ? rem : q_job.len - LEN_W'(1);
  assign fire      = cur_valid && (!out_valid || out_ready);
  assign pop       = fire && !active;

  always_comb begin
    case (idx)
      LEN_W'(0): shifted = cur.data;
      LEN_W'(1): shifted = cur.data >> 6;
      LEN_W'(2): shifted = cur.data >> 12;
      LEN_W'(3): shifted = cur.data >> 18;
      LEN_W'(4): shifted = cur.data >> 24;
      default:   shifted = cur.data >> 30;
    endcase
  end

  always_comb begin
    if (cur.len == LEN_W'(1)) begin
      byte_val = cur.data[7:0];
    end else if (!active) begin
      byte_val = lead_byte(cur.len) | shifted[7:0];
    end else begin
      byte_val = {2'b10, shifted[5:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (fire) begin
        if (!active) begin
          if (idx != '0) begin
            active <= 1'b1;
          end
        end else if (rem == '0) begin
          active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte <= byte_val;
      last     <= cur.last;
      error    <= cur.error;
      if (!active) begin
        held <= q_job;
        rem  <= idx - LEN_W'(1);
      end else begin
        rem  <= rem - LEN_W'(1);
      end
    end
  end

  a_error_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error) |-> last)
    else $error("back: error result not marked last");
  a_active_multi: assert property (@(posedge clk) disable iff (rst)
    active |-> (held.len > LEN_W'(1) && !held.last && rem < held.len))
    else $error("back: held job is not a multi-byte sequence");

endmodule

// ----- rtl/core/escape_to_utf8_decoder.sv -----
// Top level of the escape-to-UTF-8 decoder: front end, job queue, back end.
// An item's first result passes the job queue, then the back end's output register.
// Throughput: one item per cycle while the queue is not full; a multi-byte UTF-8
// sequence holds the back end until all its bytes are sent, one output byte per cycle
// unless out_ready stalls it. Reset (rst, synchronous): escape state clears, the queue empties, no output.
module escape_to_utf8_decoder #(
  parameter int QUEUE_DEPTH = etud_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       kind,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last,
  output logic       error
);
  import etud_pkg::*;

  logic push, full, pop, q_valid;
  job_t push_job, head;

  etud_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .in_byte  (in_byte),
    .q_full   (full),
    .push     (push),
    .push_job (push_job)
  );

  etud_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .q_valid  (q_valid),
    .head     (head)
  );

  etud_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_job     (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last      (last),
    .error     (error)
  );

endmodule
